### src/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

   // Width of the decoded length; longer extended lengths saturate.
   localparam int LEN_WIDTH = 64;
   localparam int CAP_WIDTH = 64;

   localparam logic [CAP_WIDTH-1:0] MAX_LEN_RESET = CAP_WIDTH'(10 * 1024 * 1024);

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [3:0] KEY_BYTES      = 4'd4;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_REJECT = 2'd2,
      KIND_ABORT  = 2'd3
   } wsdf_kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       link_closed;
   } wsdf_req_type;

   typedef struct packed {
      wsdf_kind_type out_kind;
      logic [3:0]    opcode;
      logic          masked;
      logic [63:0]   payload_length;
      logic [7:0]    data_byte;
      logic          last;
   } wsdf_rsp_type;

endpackage

### src/wsdf_in_stage.sv
// Input register: holds one received request until the parser consumes it.
module wsdf_in_stage
   import wsdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  wsdf_req_type req_item,
   input  logic         consume,
   output logic         item_valid,
   output wsdf_req_type item
);

   logic         valid_ff;
   logic         valid_in;
   wsdf_req_type item_ff;
   logic         load;

   assign req_stall = valid_ff && !consume;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### src/wsdf_parser.sv
// Frame header state machine, length decode, cap check and payload unmasking.
module wsdf_parser
   import wsdf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 consume,
   input  wsdf_req_type         item,
   input  logic [CAP_WIDTH-1:0] max_len,
   output logic                 res_valid,
   output wsdf_rsp_type         res
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [3:0]           opcode_ff, opcode_in;
   logic                 mask_ff, mask_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic [3:0]           count_ff, count_in;
   logic [31:0]          key_ff, key_in;
   logic [LEN_WIDTH-1:0] left_ff, left_in;
   logic [1:0]           pos_ff, pos_in;

   logic                 do_after;
   logic                 do_finish;
   logic [7:0]           b;
   logic [6:0]           len7;
   logic [7:0]           key_byte;
   logic                 data_last;

   assign b    = item.in_byte;
   assign len7 = b[6:0];

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      do_after  = 1'b0;
      do_finish = 1'b0;
      res_valid = 1'b0;
      res.out_kind  = KIND_HEADER;
      res.data_byte = '0;
      res.last      = 1'b0;
      key_byte  = key_ff[31:24];
      data_last = 1'b0;

      if (item.link_closed) begin
         if (phase_ff != PH_HDR0) begin
            res_valid    = 1'b1;
            res.out_kind = KIND_ABORT;
         end
         phase_in = PH_HDR0;
      end else begin
         unique case (phase_ff)
            PH_HDR0: begin
               opcode_in = b[3:0];
               mask_in   = 1'b0;
               len_in    = '0;
               key_in    = '0;
               count_in  = '0;
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = b[7];
               len_in  = '0;
               if (len7 == LEN_CODE_EXT16 || len7 == LEN_CODE_EXT64) begin
                  count_in = (len7 == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  phase_in = PH_EXT;
               end else begin
                  len_in   = LEN_WIDTH'(len7);
                  do_after = 1'b1;
               end
            end
            PH_EXT: begin
               // saturate once the top byte is occupied
               if (len_ff[LEN_WIDTH-1 -: 8] != 8'd0) begin
                  len_in = '1;
               end else begin
                  len_in = {len_ff[LEN_WIDTH-9:0], b};
               end
               count_in = count_ff - 4'd1;
               do_after = (count_in == 4'd0);
            end
            PH_KEY: begin
               key_in    = {key_ff[23:0], b};
               count_in  = count_ff - 4'd1;
               do_finish = (count_in == 4'd0);
            end
            PH_DATA: begin
               case (pos_ff)
                  2'd0:    key_byte = key_ff[31:24];
                  2'd1:    key_byte = key_ff[23:16];
                  2'd2:    key_byte = key_ff[15:8];
                  default: key_byte = key_ff[7:0];
               endcase
               pos_in        = pos_ff + 2'd1;
               data_last     = (left_ff <= LEN_WIDTH'(1));
               res_valid     = 1'b1;
               res.out_kind  = KIND_DATA;
               res.data_byte = mask_ff ? (b ^ key_byte) : b;
               res.last      = data_last;
               if (data_last) begin
                  left_in  = '0;
                  phase_in = PH_HDR0;
               end else begin
                  left_in = left_ff - LEN_WIDTH'(1);
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         if (do_after) begin
            if (mask_in) begin
               count_in = KEY_BYTES;
               key_in   = '0;
               phase_in = PH_KEY;
            end else begin
               do_finish = 1'b1;
            end
         end

         if (do_finish) begin
            res_valid = 1'b1;
            if (CAP_WIDTH'(len_in) > max_len) begin
               res.out_kind = KIND_REJECT;
               phase_in     = PH_HDR0;
            end else begin
               res.out_kind = KIND_HEADER;
               res.last     = (len_in == '0);
               if (len_in == '0) begin
                  phase_in = PH_HDR0;
               end else begin
                  left_in  = len_in;
                  pos_in   = 2'd0;
                  phase_in = PH_DATA;
               end
            end
         end
      end

      res.opcode         = opcode_in;
      res.masked         = mask_in;
      res.payload_length = 64'(len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         len_ff    <= '0;
         count_ff  <= '0;
         key_ff    <= '0;
         left_ff   <= '0;
         pos_ff    <= '0;
      end else if (consume) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

### src/wsdf_out_stage.sv
// Result register: holds a finished result until the downstream side takes it.
module wsdf_out_stage
   import wsdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  wsdf_rsp_type res,
   output logic         slot_free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output wsdf_rsp_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   wsdf_rsp_type item_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### src/websocket_frame_deframer.sv
// WebSocket deframer: one byte per cycle unless stalled, at most one result per byte.
// Takes one stream byte per cycle unless the result register is stalled. A request sits
// in an input register, passes through the header/payload parser and lands in a result
// register; the result is presented from there once the parser consumes the request. A
// byte that produces no result (header, extended length and key bytes) still passes the
// input register and parser. req_stall rises only while a request is held and the result
// register is occupied and stalled. The payload cap (csr_wr_data) resets to 10 MiB and
// should be written only while idle. Lengths are checked against the cap as the header
// completes; rejected frames are not skipped, the next byte is parsed as a fresh header.
module websocket_frame_deframer
   import wsdf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wsdf_req_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wsdf_rsp_type         rsp_item,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data
);

   logic [CAP_WIDTH-1:0] max_len_ff;
   logic                 item_valid;
   wsdf_req_type         item;
   logic                 slot_free;
   logic                 consume;
   logic                 res_valid;
   wsdf_rsp_type         res;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign consume = item_valid && slot_free;

   wsdf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   wsdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .item      (item),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   wsdf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // back-pressure only ever comes from a stalled, occupied result register
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked result");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.out_kind == KIND_HEADER)
         |-> (rsp_item.last == (rsp_item.payload_length == 64'd0)))
      else $error("header last mark disagrees with payload length");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.out_kind != KIND_DATA) |-> (rsp_item.data_byte == 8'd0))
      else $error("data byte set on a non-payload result");

   a_hold_no_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result overwritten");

endmodule

### bench/wsdf_checker.sv
// Checker for the WebSocket deframer: predicts results from accepted requests and compares them.
`timescale 1ns / 1ps
module wsdf_checker
   import wsdf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  wsdf_req_type         req_item,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  wsdf_rsp_type         rsp_item,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data,
   output int                   fail_count,
   output int                   outstanding
);

   typedef enum logic [2:0] {
      PARSE_HDR0,
      PARSE_HDR1,
      PARSE_EXT_LEN,
      PARSE_KEY,
      PARSE_DATA
   } parse_state_type;

   localparam logic [63:0] LEN_SATURATED = 64'({LEN_WIDTH{1'b1}});
   localparam int          REPORT_LIMIT  = 10;

   parse_state_type      parse_state;
   logic [CAP_WIDTH-1:0] cap;
   logic [3:0]           frame_opcode;
   logic                 frame_masked;
   logic [63:0]          frame_length;
   logic [3:0]           header_left;
   logic [31:0]          mask_key;
   logic [63:0]          payload_left;
   logic [1:0]           key_index;
   wsdf_rsp_type         expected_rsps[$];
   int                   mismatches;

   function automatic string describe(input wsdf_rsp_type r);
      return $sformatf("kind=%0d op=%h masked=%b len=%h data=%h last=%b",
                       r.out_kind, r.opcode, r.masked, r.payload_length, r.data_byte, r.last);
   endfunction

   task automatic queue_result(input wsdf_kind_type kind, input logic [7:0] data,
                               input logic last);
      wsdf_rsp_type r;
      r.out_kind       = kind;
      r.opcode         = frame_opcode;
      r.masked         = frame_masked;
      r.payload_length = frame_length;
      r.data_byte      = data;
      r.last           = last;
      expected_rsps = {expected_rsps, r};
   endtask

   // header complete: check against the cap, then either report or start the payload
   task automatic close_header();
      if (frame_length > cap) begin
         queue_result(KIND_REJECT, 8'h00, 1'b0);
         parse_state = PARSE_HDR0;
      end else begin
         queue_result(KIND_HEADER, 8'h00, frame_length == 0);
         if (frame_length == 0) begin
            parse_state = PARSE_HDR0;
         end else begin
            payload_left = frame_length;
            key_index    = '0;
            parse_state  = PARSE_DATA;
         end
      end
   endtask

   task automatic length_done();
      if (frame_masked) begin
         header_left = KEY_BYTES;
         mask_key    = '0;
         parse_state = PARSE_KEY;
      end else begin
         close_header();
      end
   endtask

   task automatic parse_request(input wsdf_req_type r);
      logic [7:0] b;
      logic       final_byte;
      b = r.in_byte;
      if (r.link_closed) begin
         // a close between frames has nothing to abort
         if (parse_state != PARSE_HDR0) begin
            queue_result(KIND_ABORT, 8'h00, 1'b0);
            parse_state = PARSE_HDR0;
         end
      end else begin
         case (parse_state)
            PARSE_HDR0: begin
               frame_opcode = b[3:0];
               frame_masked = 1'b0;
               frame_length = '0;
               mask_key     = '0;
               header_left  = '0;
               parse_state  = PARSE_HDR1;
            end
            PARSE_HDR1: begin
               frame_masked = b[7];
               frame_length = '0;
               if (b[6:0] == LEN_CODE_EXT16 || b[6:0] == LEN_CODE_EXT64) begin
                  header_left = (b[6:0] == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  parse_state = PARSE_EXT_LEN;
               end else begin
                  frame_length = 64'(b[6:0]);
                  length_done();
               end
            end
            PARSE_EXT_LEN: begin
               // big-endian; sticks at all ones once the top byte is occupied
               if ((frame_length >> (LEN_WIDTH - 8)) != 0)
                  frame_length = LEN_SATURATED;
               else
                  frame_length = ((frame_length << 8) | 64'(b)) & LEN_SATURATED;
               header_left = header_left - 1'b1;
               if (header_left == 0) length_done();
            end
            PARSE_KEY: begin
               mask_key    = {mask_key[23:0], b};
               header_left = header_left - 1'b1;
               if (header_left == 0) close_header();
            end
            PARSE_DATA: begin
               if (frame_masked) b = b ^ mask_key[8 * (3 - int'(key_index)) +: 8];
               key_index  = key_index + 1'b1;
               final_byte = (payload_left <= 1);
               queue_result(KIND_DATA, b, final_byte);
               if (final_byte) begin
                  payload_left = '0;
                  parse_state  = PARSE_HDR0;
               end else begin
                  payload_left = payload_left - 1;
               end
            end
            default: parse_state = PARSE_HDR0;
         endcase
      end
   endtask

   always @(posedge clock) begin
      wsdf_rsp_type exp_rsp;
      if (reset) begin
         cap          = MAX_LEN_RESET;
         parse_state  = PARSE_HDR0;
         frame_opcode = '0;
         frame_masked = 1'b0;
         frame_length = '0;
         header_left  = '0;
         mask_key     = '0;
         payload_left = '0;
         key_index    = '0;
         mismatches   = 0;
         expected_rsps.delete();
      end else begin
         if (csr_wr_en) cap = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result with none expected: %s", $time, describe(rsp_item));
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_item.out_kind !== exp_rsp.out_kind || rsp_item.opcode !== exp_rsp.opcode
                   || rsp_item.masked !== exp_rsp.masked
                   || rsp_item.payload_length !== exp_rsp.payload_length
                   || rsp_item.data_byte !== exp_rsp.data_byte
                   || rsp_item.last !== exp_rsp.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: expected %s, got %s", $time, describe(exp_rsp),
                              describe(rsp_item));
               end
            end
         end
         if (req_valid && !req_stall) parse_request(req_item);
      end
      fail_count  <= mismatches;
      outstanding <= expected_rsps.size();
   end

endmodule

### bench/tb_top.sv
// Testbench top for the WebSocket deframer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import wsdf_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int PHASE_COUNT     = 8;
   localparam int BYTES_PER_PHASE = 68;
   localparam int DRAIN_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SHORT_PAYLOAD   = 64;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   wsdf_req_type         req_item    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   wsdf_rsp_type         rsp_item;
   logic                 csr_wr_en   = 1'b0;
   logic [CAP_WIDTH-1:0] csr_wr_data = '0;
   logic [CAP_WIDTH-1:0] cap_value   = MAX_LEN_RESET;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent_bytes    = 0;
   int quiet_cycles  = 0;

   websocket_frame_deframer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   wsdf_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // valid stays high on return; the caller's next drive decides what follows
   task automatic send_request(input wsdf_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (req_stall);
      if (!r.link_closed) sent_bytes++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      wsdf_req_type r;
      r.in_byte     = b;
      r.link_closed = 1'b0;
      send_request(r);
   endtask

   task automatic send_close();
      wsdf_req_type r;
      r.in_byte     = 8'($urandom);
      r.link_closed = 1'b1;
      send_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // a byte with no result may still be in the pipe
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cap(input logic [CAP_WIDTH-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_value    = value;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 69;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 69;
         end
         default: begin
            send_idle_pct = 14;
            stall_pct     = 14;
         end
      endcase
   endtask

   task automatic send_random_frame();
      logic [7:0]  header[$];
      logic [63:0] len;
      logic [6:0]  code;
      logic        masked;
      int          sel;
      int          ext_bytes;
      int          cut;
      int          n_data;
      masked    = 1'($urandom_range(0, 1));
      sel       = $urandom_range(0, 99);
      ext_bytes = 0;
      if (sel < 60) begin
         code = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 125))
                                            : 7'($urandom_range(0, 24));
         len  = 64'(code);
      end else if (sel < 80) begin
         code      = LEN_CODE_EXT16;
         ext_bytes = int'(EXT16_BYTES);
         len       = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
                                                 : 64'($urandom_range(0, 300));
      end else begin
         code      = LEN_CODE_EXT64;
         ext_bytes = int'(EXT64_BYTES);
         len       = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                 : 64'($urandom_range(0, 300));
      end
      // upper nibble is FIN/RSV, ignored by the parser
      header = {header, 8'($urandom)};
      header = {header, {masked, code}};
      for (int i = ext_bytes - 1; i >= 0; i--) header = {header, len[8 * i +: 8]};
      if (masked) repeat (int'(KEY_BYTES)) header = {header, 8'($urandom)};

      if ($urandom_range(0, 99) < 8) begin
         // link drops part way through the header
         cut = $urandom_range(1, header.size() - 1);
         for (int i = 0; i < cut; i++) send_byte(header[i]);
         send_close();
      end else begin
         foreach (header[i]) send_byte(header[i]);
         // rejected frames get no payload: the next byte is a fresh header
         if (len <= cap_value && len != 0) begin
            if (len <= SHORT_PAYLOAD && $urandom_range(0, 9) != 0)
               n_data = int'(len);
            else
               n_data = $urandom_range(0, (len <= SHORT_PAYLOAD) ? int'(len) - 1 : 16);
            repeat (n_data) send_byte(8'($urandom));
            if (64'(n_data) < len) send_close();
         end
      end
   endtask

   // junk bytes and stray closes, then a close to get back to a header
   task automatic send_noise();
      wsdf_req_type r;
      repeat ($urandom_range(1, 6)) begin
         r.in_byte     = 8'($urandom);
         r.link_closed = ($urandom_range(0, 3) == 0);
         send_request(r);
      end
      send_close();
   endtask

   initial begin
      logic [7:0]           directed[$];
      logic [CAP_WIDTH-1:0] caps[PHASE_COUNT];
      int                   start;
      int                   sel;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // close while idle, empty frame, masked one-byte frame, 16-bit length,
      // 64-bit length over the reset cap, then a close after one header byte
      send_close();
      directed = {8'h8F, 8'h00,
                  8'h82, 8'h81, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h3C,
                  8'h00, 8'h7E, 8'h00, 8'h01, 8'h77,
                  8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                  8'h0A};
      foreach (directed[i]) send_byte(directed[i]);
      send_close();

      caps[0] = MAX_LEN_RESET;
      caps[1] = '0;
      caps[2] = '1;
      caps[3] = CAP_WIDTH'(300);
      caps[4] = CAP_WIDTH'($urandom_range(1, 200));
      caps[5] = CAP_WIDTH'(40);
      caps[6] = {$urandom, $urandom};
      caps[7] = '1;

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_cap(caps[ph]);
         set_idling(idle_mode_type'(ph % 4));
         start = sent_bytes;
         while (sent_bytes - start < BYTES_PER_PHASE) begin
            sel = $urandom_range(0, 99);
            if (sel < 82)
               send_random_frame();
            else if (sel < 96)
               send_noise();
            else
               wait_drained();
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
src/wsdf_pkg.sv
src/wsdf_in_stage.sv
src/wsdf_parser.sv
src/wsdf_out_stage.sv
src/websocket_frame_deframer.sv
bench/wsdf_checker.sv
bench/tb_top.sv
